// ===== sv/mtte_pkg.sv =====
// Shared types, constants and the Morse symbol table of the text-to-tone encoder.
package mtte_pkg;

  // Default message capacity in notes.
  localparam int MAX_NOTES_DEF = 64;

  // Configuration register indexes.
  localparam logic [2:0] REG_DOT_MS         = 3'd0;
  localparam logic [2:0] REG_DASH_MS        = 3'd1;
  localparam logic [2:0] REG_ELEMENT_GAP_MS = 3'd2;
  localparam logic [2:0] REG_LETTER_GAP_MS  = 3'd3;
  localparam logic [2:0] REG_TONE_HZ        = 3'd4;

  // Configuration reset values.
  localparam logic [9:0]  DOT_MS_RST         = 10'd70;
  localparam logic [11:0] DASH_MS_RST        = 12'd210;
  localparam logic [9:0]  ELEMENT_GAP_MS_RST = 10'd70;
  localparam logic [11:0] LETTER_GAP_MS_RST  = 12'd210;
  localparam logic [14:0] TONE_HZ_RST        = 15'd2700;

  // Character codes used by the decoder.
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // Table position of the first digit; letters occupy the positions below it.
  localparam logic [5:0] DIGIT_BASE = 6'd26;

  typedef struct packed {
    logic [7:0] character;
    logic       start_message;
  } in_word_t;

  typedef struct packed {
    logic [14:0] note_hz;
    logic [12:0] note_ms;
    logic        last;
  } out_word_t;

  // One symbol: element count and pattern, a one is a dash, first element in bit len-1.
  typedef struct packed {
    logic [2:0] len;
    logic [4:0] bits;
  } morse_sym_t;

  typedef struct packed {
    logic load;
    logic emit;
  } mtte_cmd_t;

  typedef struct packed {
    logic done;
    logic last_note;
  } mtte_status_t;

  function automatic morse_sym_t sym_lookup(input logic [5:0] idx);
    morse_sym_t s;
    unique case (idx)
      6'd0:  s = '{3'd2, 5'd1};
      6'd1:  s = '{3'd4, 5'd8};
      6'd2:  s = '{3'd4, 5'd10};
      6'd3:  s = '{3'd3, 5'd4};
      6'd4:  s = '{3'd1, 5'd0};
      6'd5:  s = '{3'd4, 5'd2};
      6'd6:  s = '{3'd3, 5'd6};
      6'd7:  s = '{3'd4, 5'd0};
      6'd8:  s = '{3'd2, 5'd0};
      6'd9:  s = '{3'd4, 5'd7};
      6'd10: s = '{3'd3, 5'd5};
      6'd11: s = '{3'd4, 5'd4};
      6'd12: s = '{3'd2, 5'd3};
      6'd13: s = '{3'd2, 5'd2};
      6'd14: s = '{3'd3, 5'd7};
      6'd15: s = '{3'd4, 5'd6};
      6'd16: s = '{3'd4, 5'd13};
      6'd17: s = '{3'd3, 5'd2};
      6'd18: s = '{3'd3, 5'd0};
      6'd19: s = '{3'd1, 5'd1};
      6'd20: s = '{3'd3, 5'd1};
      6'd21: s = '{3'd4, 5'd1};
      6'd22: s = '{3'd3, 5'd3};
      6'd23: s = '{3'd4, 5'd9};
      6'd24: s = '{3'd4, 5'd11};
      6'd25: s = '{3'd4, 5'd12};
      6'd26: s = '{3'd5, 5'd31};
      6'd27: s = '{3'd5, 5'd15};
      6'd28: s = '{3'd5, 5'd7};
      6'd29: s = '{3'd5, 5'd3};
      6'd30: s = '{3'd5, 5'd1};
      6'd31: s = '{3'd5, 5'd0};
      6'd32: s = '{3'd5, 5'd16};
      6'd33: s = '{3'd5, 5'd24};
      6'd34: s = '{3'd5, 5'd28};
      6'd35: s = '{3'd5, 5'd30};
      default: s = '{3'd0, 5'd0};
    endcase
    return s;
  endfunction

endpackage

// ===== sv/mtte_ctrl.sv =====
// Sequencing state machine of the text-to-tone encoder.
module mtte_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  mtte_pkg::mtte_status_t status,
  output mtte_pkg::mtte_cmd_t    cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // The output register can take a note when empty or being emptied this cycle.
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.load      = 1'b0;
    cmd.emit      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.done) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          if (status.last_note) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== sv/mtte_dp.sv =====
// Datapath of the text-to-tone encoder: registers, decoder, note counter and output word.
module mtte_dp #(
  parameter int MAX_NOTES = mtte_pkg::MAX_NOTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic [2:0]             cfg_index,
  input  logic [14:0]            cfg_data,
  input  mtte_pkg::in_word_t     in_word,
  input  mtte_pkg::mtte_cmd_t    cmd,
  output mtte_pkg::mtte_status_t status,
  output mtte_pkg::out_word_t    out_word
);

  localparam int CW = $clog2(MAX_NOTES + 1);

  logic [9:0]  dot_r;
  logic [11:0] dash_r;
  logic [9:0]  egap_r;
  logic [11:0] lgap_r;
  logic [14:0] tone_r;

  logic [CW-1:0] count_r, count_nxt;
  logic [3:0]    idx_r, n_emit_r;
  logic          space_r;
  logic [2:0]    len_r;
  logic [4:0]    bits_r;
  mtte_pkg::out_word_t out_word_r;

  // Character decode and note budget, evaluated on the incoming word.
  logic [7:0]  ch;
  logic [7:0]  letter_off;
  logic [7:0]  digit_off;
  logic        is_letter, is_digit, is_space;
  logic [5:0]  tab_idx;
  mtte_pkg::morse_sym_t sym;
  logic [3:0]  total;
  logic [CW-1:0] left;
  logic [3:0]  n_emit;

  always_comb begin
    ch = in_word.character;
    if (ch >= mtte_pkg::CHAR_LOWER_A && ch <= mtte_pkg::CHAR_LOWER_Z) begin
      ch = ch - mtte_pkg::CASE_OFFSET;
    end
    is_space   = (ch == mtte_pkg::CHAR_SPACE);
    is_letter  = (ch >= mtte_pkg::CHAR_UPPER_A) && (ch <= mtte_pkg::CHAR_UPPER_Z);
    is_digit   = (ch >= mtte_pkg::CHAR_ZERO) && (ch <= mtte_pkg::CHAR_NINE);
    letter_off = ch - mtte_pkg::CHAR_UPPER_A;
    digit_off  = ch - mtte_pkg::CHAR_ZERO;
    tab_idx    = is_letter ? {1'b0, letter_off[4:0]}
                           : ({2'b00, digit_off[3:0]} + mtte_pkg::DIGIT_BASE);
    sym        = mtte_pkg::sym_lookup(tab_idx);
    // Each element is a tone and a gap, then one letter gap: 2*len+1 notes.
    if (is_space) begin
      total = 4'd1;
    end else if (is_letter || is_digit) begin
      total = {sym.len, 1'b1};
    end else begin
      total = 4'd0;
    end
    count_nxt = in_word.start_message ? '0 : count_r;
    left      = CW'(MAX_NOTES) - count_nxt;
    n_emit    = (CW'(total) <= left) ? total : left[3:0];
  end

  // Note generator for the current position in the sequence.
  logic [2:0]  el;
  logic        is_dash;
  mtte_pkg::out_word_t note;

  always_comb begin
    el      = len_r - idx_r[3:1] - 3'd1;
    is_dash = bits_r[el];
    note.last = (4'(idx_r + 4'd1) == n_emit_r);
    if (space_r) begin
      note.note_hz = '0;
      note.note_ms = {lgap_r, 1'b0};
    end else if (idx_r == {len_r, 1'b0}) begin
      note.note_hz = '0;
      note.note_ms = {1'b0, lgap_r};
    end else if (idx_r[0]) begin
      note.note_hz = '0;
      note.note_ms = {3'b000, egap_r};
    end else begin
      note.note_hz = tone_r;
      note.note_ms = is_dash ? {1'b0, dash_r} : {3'b000, dot_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r  <= mtte_pkg::DOT_MS_RST;
      dash_r <= mtte_pkg::DASH_MS_RST;
      egap_r <= mtte_pkg::ELEMENT_GAP_MS_RST;
      lgap_r <= mtte_pkg::LETTER_GAP_MS_RST;
      tone_r <= mtte_pkg::TONE_HZ_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mtte_pkg::REG_DOT_MS:         dot_r  <= cfg_data[9:0];
        mtte_pkg::REG_DASH_MS:        dash_r <= cfg_data[11:0];
        mtte_pkg::REG_ELEMENT_GAP_MS: egap_r <= cfg_data[9:0];
        mtte_pkg::REG_LETTER_GAP_MS:  lgap_r <= cfg_data[11:0];
        mtte_pkg::REG_TONE_HZ:        tone_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      idx_r    <= '0;
      n_emit_r <= '0;
    end else if (cmd.load) begin
      count_r  <= count_nxt;
      idx_r    <= '0;
      n_emit_r <= n_emit;
    end else if (cmd.emit) begin
      count_r  <= count_r + CW'(1);
      idx_r    <= idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      space_r <= is_space;
      len_r   <= sym.len;
      bits_r  <= sym.bits;
    end
    if (cmd.emit) begin
      out_word_r <= note;
    end
  end

  assign status.done      = (idx_r == n_emit_r);
  assign status.last_note = note.last;
  assign out_word         = out_word_r;

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_NOTES))
    else $error("note count passed the message capacity");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (idx_r < n_emit_r))
    else $error("note emitted beyond the budget of its character");

  a_emit_counts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (count_r == CW'($past(count_r) + CW'(1))))
    else $error("emitted note not counted");
`endif

endmodule

// ===== sv/morse_text_to_tone_encoder.sv =====
// Top level of the Morse text-to-tone encoder: controller and datapath.
//
// Text characters arrive as words on the in_ channel (in_valid, in_stall,
// in_word); each accepted character produces zero to eleven note words on
// the out_ channel (out_valid, out_stall, out_word). A note is a frequency
// (zero for silence) and a duration in milliseconds; last marks the final
// note of a character. Letters and digits give tone and element-gap pairs
// followed by a letter gap, a space gives one silent note of twice the
// letter gap, and any other character gives nothing.
// A character is taken while idle; the sequencer then loads one note per
// cycle into the output register unless the receiver stalls, and the
// input stalls until it is idle again. The next character is accepted
// while the final note still waits in the output register. When the
// receiver stalls, the output register holds its word and the sequencer
// waits with it. Notes beyond MAX_NOTES since the last start_message are
// dropped. Reset clears the note count, returns the registers to their
// defaults and empties the output register. The user must write registers
// over the always-ready cfg_ port only while idle; this is not enforced.
module morse_text_to_tone_encoder #(
  parameter int MAX_NOTES = mtte_pkg::MAX_NOTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mtte_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output mtte_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [14:0]         cfg_data
);

  mtte_pkg::mtte_cmd_t    cmd;
  mtte_pkg::mtte_status_t status;

  // Register writes never wait.
  assign cfg_ready = 1'b1;

  mtte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mtte_dp #(
    .MAX_NOTES (MAX_NOTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .cmd       (cmd),
    .status    (status),
    .out_word  (out_word)
  );

endmodule
